>>> design/dic_pkg.sv
package dic_pkg;

	localparam int unsigned TankW   = 4;
	localparam int unsigned CupW    = 2;
	localparam int unsigned CharW   = 8;
	localparam int unsigned PumpW   = 3;
	localparam int unsigned MsgW    = 4;
	localparam int unsigned ShownW  = 3;
	localparam int unsigned TicksW  = 8;
	localparam int unsigned InDataW  = 16;
	localparam int unsigned OutDataW = 16;
	localparam int unsigned OutUserW = 3;

	localparam logic [TicksW-1:0] TIMEOUT_RESET = 8'd20;
	localparam logic [TicksW-1:0] TICKS_MAX     = 8'hFF;

	// display message codes
	localparam logic [MsgW-1:0] MSG_SPILL    = 4'd0;
	localparam logic [MsgW-1:0] MSG_SELECT   = 4'd6;
	localparam logic [MsgW-1:0] MSG_DISP_BASE = 4'd7;

	// shown-fault tracking codes: 0 none, 1..6 fault index plus one, 7 select
	localparam logic [ShownW-1:0] SHOWN_NONE   = 3'd0;
	localparam logic [ShownW-1:0] SHOWN_SELECT = 3'd7;

	// command bytes
	localparam logic [CharW-1:0] CMD_COKE   = 8'h43; // 'C'
	localparam logic [CharW-1:0] CMD_SPRITE = 8'h53; // 'S'
	localparam logic [CharW-1:0] CMD_WATER  = 8'h57; // 'W'
	localparam logic [CharW-1:0] CMD_NONE   = 8'h00;

	// host status bytes
	localparam logic [CharW-1:0] ST_CLEAR   = 8'h23; // '#'
	localparam logic [CharW-1:0] ST_STOPPED = 8'h58; // 'X'
	localparam logic [CharW-1:0] ST_OTHER   = 8'h39; // '9'
	localparam logic [CharW-1:0] ST_NONE    = 8'h00;

	// fault index: spill, cup full, coke low, sprite low, water low, cup missing
	typedef enum logic [2:0] {
		FLT_SPILL   = 3'd0,
		FLT_FULL    = 3'd1,
		FLT_COKE    = 3'd2,
		FLT_SPRITE  = 3'd3,
		FLT_WATER   = 3'd4,
		FLT_NOCUP   = 3'd5
	} fault_t;

	typedef enum logic [1:0] {
		SEL_COKE   = 2'd0,
		SEL_SPRITE = 2'd1,
		SEL_WATER  = 2'd2
	} sel_t;

	typedef struct packed {
		logic             rx_taken;
		logic             message_write;
		logic             status_valid;
		logic [MsgW-1:0]  message_code;
		logic [CharW-1:0] status_byte;
		logic [PumpW-1:0] pump_bits;
	} result_t;

	function automatic logic [CharW-1:0] fault_status(input fault_t f);
		logic [CharW-1:0] s;
		s = 8'h46;
		unique case (f)
			FLT_SPILL:  s = 8'h46; // 'F'
			FLT_FULL:   s = 8'h44; // 'D'
			FLT_COKE:   s = 8'h4B; // 'K'
			FLT_SPRITE: s = 8'h4D; // 'M'
			FLT_WATER:  s = 8'h50; // 'P'
			FLT_NOCUP:  s = 8'h4A; // 'J'
			default:    s = 8'h46;
		endcase
		return s;
	endfunction

	function automatic logic [CharW-1:0] go_status(input sel_t s);
		logic [CharW-1:0] r;
		r = 8'h51;
		unique case (s)
			SEL_COKE:   r = 8'h51; // 'Q'
			SEL_SPRITE: r = 8'h52; // 'R'
			SEL_WATER:  r = 8'h54; // 'T'
			default:    r = 8'h51;
		endcase
		return r;
	endfunction

endpackage

>>> design/dispenser_interlock_controller.sv
// Dispenser interlock controller: one polling tick per request.
// A request taken into the input register is run through the tick logic and loaded into
// the result register once the result slot is free or is being drained.
// Throughput: one request per cycle; while a result waits, the input register takes one
// more request and then holds tready low until the result drains.
// Reset (arst_n low, asynchronous): pumps off, no fault shown, status zero, not
// dispensing, tick counter zero, message code zero, timeout 20 ticks, both stages empty.
module dispenser_interlock_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	// tick request: tank_sensors[3:0], cup_sensors[5:4], rx_char[13:6], zero pad [15:14]
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [dic_pkg::InDataW-1:0]      s_axis_tdata,
	// rx_valid[0]
	input  logic                             s_axis_tuser,
	// result: pump_bits[2:0], status_byte[10:3], message_code[14:11], zero pad [15]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [dic_pkg::OutDataW-1:0]     m_axis_tdata,
	// status_valid[0], message_write[1], rx_taken[2]
	output logic [dic_pkg::OutUserW-1:0]     m_axis_tuser,
	// timeout_ticks write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dic_pkg::TicksW-1:0]       cfg_data
);
	import dic_pkg::*;

	// input stage
	logic              valid_s1;
	logic [TankW-1:0]  tank_s1;
	logic [CupW-1:0]   cup_s1;
	logic              rxv_s1;
	logic [CharW-1:0]  rx_s1;

	// result stage
	logic              valid_s2;
	result_t           res_s2;

	// controller state
	logic [PumpW-1:0]  pump_q;
	logic [ShownW-1:0] shown_q;
	logic [CharW-1:0]  status_q;
	logic              pending_q;
	logic              disp_q;
	logic [TicksW-1:0] elapsed_q;
	logic [MsgW-1:0]   msg_q;
	logic [TicksW-1:0] timeout_q;

	// next state
	logic [PumpW-1:0]  n_pump;
	logic [ShownW-1:0] n_shown;
	logic [CharW-1:0]  n_status;
	logic              n_pending;
	logic              n_disp;
	logic [TicksW-1:0] n_elapsed;
	logic [MsgW-1:0]   n_msg;
	logic              wrote;
	logic              taken;
	logic [CharW-1:0]  sent;

	logic              fault_hit;
	fault_t            fault_idx;
	logic              sel_hit;
	sel_t              sel;
	logic              advance;

	// Move the input stage into the result register whenever the result slot is free
	// or is being drained this cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tank_s1 <= s_axis_tdata[TankW-1:0];
			cup_s1  <= s_axis_tdata[TankW+CupW-1:TankW];
			rx_s1   <= s_axis_tdata[TankW+CupW+CharW-1:TankW+CupW];
			rxv_s1  <= s_axis_tuser;
		end
	end

	// Sensor priority: spill, cup full, coke low, sprite low, water low, cup missing.
	always_comb begin
		fault_hit = 1'b1;
		fault_idx = FLT_SPILL;
		if (!tank_s1[0]) begin
			fault_idx = FLT_SPILL;
		end else if (!tank_s1[1]) begin
			fault_idx = FLT_FULL;
		end else if (tank_s1[2]) begin
			fault_idx = FLT_COKE;
		end else if (tank_s1[3]) begin
			fault_idx = FLT_SPRITE;
		end else if (cup_s1[0]) begin
			fault_idx = FLT_WATER;
		end else if (cup_s1[1]) begin
			fault_idx = FLT_NOCUP;
		end else begin
			fault_hit = 1'b0;
		end
	end

	// Command decode: C, S and W pick a pump; anything else nonzero stops.
	always_comb begin
		sel_hit = 1'b1;
		sel     = SEL_COKE;
		unique case (rx_s1)
			CMD_COKE:   sel = SEL_COKE;
			CMD_SPRITE: sel = SEL_SPRITE;
			CMD_WATER:  sel = SEL_WATER;
			default:    sel_hit = 1'b0;
		endcase
	end

	// One tick: fault handling, select after clear, command, then the timeout check.
	always_comb begin
		n_pump    = pump_q;
		n_shown   = shown_q;
		n_status  = status_q;
		n_pending = pending_q;
		n_disp    = disp_q;
		n_elapsed = elapsed_q;
		n_msg     = msg_q;
		wrote     = 1'b0;
		taken     = 1'b0;

		if (fault_hit) begin
			// stop pumps on every fault tick, redraw only when the fault changes
			n_pump = '0;
			if (shown_q != ShownW'(fault_idx) + ShownW'(1)) begin
				n_shown = ShownW'(fault_idx) + ShownW'(1);
				n_msg   = MsgW'(fault_idx);
				wrote   = 1'b1;
			end
			n_status  = fault_status(fault_idx);
			n_pending = 1'b1;
		end else if (pending_q) begin
			// first clear tick after a fault: show select, leave the byte waiting
			n_status = ST_CLEAR;
			if (shown_q != SHOWN_SELECT) begin
				n_shown = SHOWN_SELECT;
				n_msg   = MSG_SELECT;
				wrote   = 1'b1;
			end
			n_pending = 1'b0;
		end else if (rxv_s1) begin
			taken = 1'b1;
			if (rx_s1 != CMD_NONE) begin
				wrote = 1'b1;
				if (sel_hit) begin
					if (disp_q) begin
						n_pump   = '0;
						n_msg    = MSG_SELECT;
						n_status = ST_STOPPED;
						n_disp   = 1'b0;
					end else begin
						n_pump   = PumpW'(1) << sel;
						n_msg    = MSG_DISP_BASE + MsgW'(sel);
						n_status = go_status(sel);
						n_disp   = 1'b1;
					end
					n_elapsed = '0;
				end else begin
					// unknown command: stop pumps, dispensing flag stays
					n_pump   = '0;
					n_msg    = MSG_SELECT;
					n_status = ST_OTHER;
				end
			end
		end

		// status sent this tick is taken before the timeout check
		sent = n_status;

		if (n_disp) begin
			if (n_elapsed != TICKS_MAX) begin
				n_elapsed = n_elapsed + TicksW'(1);
			end
			if (n_elapsed >= timeout_q) begin
				n_pump   = '0;
				n_msg    = MSG_SELECT;
				wrote    = 1'b1;
				n_disp   = 1'b0;
				n_status = ST_STOPPED;
			end
		end
	end

	// Advance state and load the result register together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q    <= '0;
			shown_q   <= SHOWN_NONE;
			status_q  <= ST_NONE;
			pending_q <= 1'b0;
			disp_q    <= 1'b0;
			elapsed_q <= '0;
			msg_q     <= MSG_SPILL;
		end else if (advance) begin
			pump_q    <= n_pump;
			shown_q   <= n_shown;
			status_q  <= n_status;
			pending_q <= n_pending;
			disp_q    <= n_disp;
			elapsed_q <= n_elapsed;
			msg_q     <= n_msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.pump_bits     <= n_pump;
			res_s2.status_byte   <= sent;
			res_s2.status_valid  <= (sent != ST_NONE);
			res_s2.message_write <= wrote;
			res_s2.message_code  <= n_msg;
			res_s2.rx_taken      <= taken;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2.message_code, res_s2.status_byte, res_s2.pump_bits};
	assign m_axis_tuser  = {res_s2.rx_taken, res_s2.message_write, res_s2.status_valid};

	// at most one pump runs at a time
	a_pump_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pump_q))
		else $error("more than one pump driven");

	// a running pump implies an active dispense
	a_pump_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(pump_q != '0) |-> disp_q)
		else $error("pump running without dispensing");

	// a fault tick always leaves the pumps stopped
	a_fault_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fault_hit) |=> (pump_q == '0) && pending_q)
		else $error("pumps not stopped on fault");

	// a consumed command byte never happens on a fault tick
	a_taken_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && taken) |-> (!fault_hit && !pending_q))
		else $error("command consumed during fault handling");

endmodule

>>> tb/dispenser_interlock_checker.sv
module dispenser_interlock_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	input  logic [dic_pkg::InDataW-1:0]  s_axis_tdata,
	input  logic                         s_axis_tuser,
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	input  logic [dic_pkg::OutDataW-1:0] m_axis_tdata,
	input  logic [dic_pkg::OutUserW-1:0] m_axis_tuser,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [dic_pkg::TicksW-1:0]   cfg_data,
	output int                           fail_count,
	output int                           results_seen,
	output int                           backlog
);
	timeunit 1ns;
	timeprecision 1ps;
	import dic_pkg::*;

	localparam logic [CharW-1:0] ST_SPILL      = 8'h46; // 'F'
	localparam logic [CharW-1:0] ST_FULL       = 8'h44; // 'D'
	localparam logic [CharW-1:0] ST_COKE_LOW   = 8'h4B; // 'K'
	localparam logic [CharW-1:0] ST_SPRITE_LOW = 8'h4D; // 'M'
	localparam logic [CharW-1:0] ST_WATER_LOW  = 8'h50; // 'P'
	localparam logic [CharW-1:0] ST_NO_CUP     = 8'h4A; // 'J'
	localparam logic [CharW-1:0] ST_GO_COKE    = 8'h51; // 'Q'
	localparam logic [CharW-1:0] ST_GO_SPRITE  = 8'h52; // 'R'
	localparam logic [CharW-1:0] ST_GO_WATER   = 8'h54; // 'T'
	localparam int               REPORT_LIMIT  = 10;

	// mirrored controller state
	logic [TicksW-1:0] timeout_ticks;
	logic [TicksW-1:0] elapsed;
	logic [PumpW-1:0]  pumps;
	logic [ShownW-1:0] shown;
	logic [CharW-1:0]  status;
	logic              fault_latched;
	logic              dispensing;
	logic [MsgW-1:0]   last_msg;

	result_t tick_results_due[$];
	result_t got;
	result_t want;
	logic    bad;
	int      n_fail;
	int      n_seen;

	// Advance the mirrored state by one polling tick and return the tick's result.
	function automatic result_t poll_tick(input logic [TankW-1:0] tank,
			input logic [CupW-1:0] cup, input logic rxv, input logic [CharW-1:0] rx);
		result_t         r;
		fault_t          flt;
		sel_t            sel;
		logic            faulted;
		logic            wrote;
		logic            taken;
		logic            is_pump;
		logic [CharW-1:0] sent;
		faulted = 1'b1;
		wrote   = 1'b0;
		taken   = 1'b0;
		is_pump = 1'b0;
		flt     = FLT_SPILL;
		sel     = SEL_COKE;
		if (!tank[0])     flt = FLT_SPILL;
		else if (!tank[1]) flt = FLT_FULL;
		else if (tank[2])  flt = FLT_COKE;
		else if (tank[3])  flt = FLT_SPRITE;
		else if (cup[0])   flt = FLT_WATER;
		else if (cup[1])   flt = FLT_NOCUP;
		else               faulted = 1'b0;

		if (faulted) begin
			pumps = '0;
			if (shown != ShownW'(flt) + 3'd1) begin
				shown    = ShownW'(flt) + 3'd1;
				last_msg = MSG_SPILL + MsgW'(flt);
				wrote    = 1'b1;
			end
			case (flt)
				FLT_SPILL:  status = ST_SPILL;
				FLT_FULL:   status = ST_FULL;
				FLT_COKE:   status = ST_COKE_LOW;
				FLT_SPRITE: status = ST_SPRITE_LOW;
				FLT_WATER:  status = ST_WATER_LOW;
				default:    status = ST_NO_CUP;
			endcase
			fault_latched = 1'b1;
		end else if (fault_latched) begin
			status = ST_CLEAR;
			if (shown != SHOWN_SELECT) begin
				shown    = SHOWN_SELECT;
				last_msg = MSG_SELECT;
				wrote    = 1'b1;
			end
			fault_latched = 1'b0;
		end else if (rxv) begin
			taken = 1'b1;
			if (rx != CMD_NONE) begin
				wrote   = 1'b1;
				is_pump = 1'b1;
				case (rx)
					CMD_COKE:   sel = SEL_COKE;
					CMD_SPRITE: sel = SEL_SPRITE;
					CMD_WATER:  sel = SEL_WATER;
					default:    is_pump = 1'b0;
				endcase
				if (is_pump) begin
					if (dispensing) begin
						pumps      = '0;
						last_msg   = MSG_SELECT;
						status     = ST_STOPPED;
						dispensing = 1'b0;
					end else begin
						pumps    = PumpW'(1) << sel;
						last_msg = MSG_DISP_BASE + MsgW'(sel);
						case (sel)
							SEL_COKE:   status = ST_GO_COKE;
							SEL_SPRITE: status = ST_GO_SPRITE;
							default:    status = ST_GO_WATER;
						endcase
						dispensing = 1'b1;
					end
					elapsed = '0;
				end else begin
					pumps    = '0;
					last_msg = MSG_SELECT;
					status   = ST_OTHER;
				end
			end
		end

		// status goes out before the timeout check of this tick
		sent = status;
		if (dispensing) begin
			if (elapsed != TICKS_MAX)
				elapsed = elapsed + 1'b1;
			if (elapsed >= timeout_ticks) begin
				pumps      = '0;
				last_msg   = MSG_SELECT;
				wrote      = 1'b1;
				dispensing = 1'b0;
				status     = ST_STOPPED;
			end
		end

		r.pump_bits     = pumps;
		r.status_byte   = sent;
		r.status_valid  = (sent != ST_NONE);
		r.message_write = wrote;
		r.message_code  = last_msg;
		r.rx_taken      = taken;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks = TIMEOUT_RESET;
			elapsed       = '0;
			pumps         = '0;
			shown         = SHOWN_NONE;
			status        = ST_NONE;
			fault_latched = 1'b0;
			dispensing    = 1'b0;
			last_msg      = MSG_SPILL;
			tick_results_due.delete();
			n_fail        = 0;
			n_seen        = 0;
			fail_count   <= 0;
			results_seen <= 0;
			backlog      <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				timeout_ticks = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				tick_results_due.push_back(poll_tick(s_axis_tdata[3:0], s_axis_tdata[5:4],
					s_axis_tuser, s_axis_tdata[13:6]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.pump_bits     = m_axis_tdata[2:0];
				got.status_byte   = m_axis_tdata[10:3];
				got.message_code  = m_axis_tdata[14:11];
				got.status_valid  = m_axis_tuser[0];
				got.message_write = m_axis_tuser[1];
				got.rx_taken      = m_axis_tuser[2];
				if (tick_results_due.size() == 0) begin
					n_fail++;
					if (n_fail <= REPORT_LIMIT)
						$display("%0t: result %0d arrived with no tick pending", $time, n_seen);
				end else begin
					want = tick_results_due.pop_front();
					bad  = (got.pump_bits !== want.pump_bits)
						|| (got.status_byte !== want.status_byte)
						|| (got.status_valid !== want.status_valid)
						|| (got.message_write !== want.message_write)
						|| (got.message_code !== want.message_code)
						|| (got.rx_taken !== want.rx_taken);
					if (bad) begin
						n_fail++;
						if (n_fail <= REPORT_LIMIT) begin
							$display("%0t: tick %0d expected pump=%h st=%h/%b msg=%0d/%b taken=%b",
								$time, n_seen, want.pump_bits, want.status_byte,
								want.status_valid, want.message_code, want.message_write,
								want.rx_taken);
							$display("%0t: tick %0d actual   pump=%h st=%h/%b msg=%0d/%b taken=%b",
								$time, n_seen, got.pump_bits, got.status_byte,
								got.status_valid, got.message_code, got.message_write,
								got.rx_taken);
						end
					end
				end
				n_seen++;
			end
			fail_count   <= n_fail;
			results_seen <= n_seen;
			backlog      <= tick_results_due.size();
		end
	end

endmodule

>>> tb/dispenser_interlock_controller_tb.sv
module dispenser_interlock_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dic_pkg::*;

	localparam int               PHASES      = 8;
	localparam int               PHASE_TICKS = 195;
	localparam logic [CharW-1:0] CMD_ODD     = 8'h5A; // 'Z', not a pump command
	localparam logic [TankW-1:0] TANK_CLEAR  = 4'b0011; // spill ok, cup not full, tanks fine
	localparam logic [CupW-1:0]  CUP_CLEAR   = 2'b00;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata;
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic [OutUserW-1:0] m_axis_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [TicksW-1:0]   cfg_data;

	int fail_count;
	int results_seen;
	int backlog;
	int ticks_sent;
	int sender_idle_pct;
	int receiver_stall_pct;

	// idle patterns cycled over the phases: none, sender only, receiver only, both
	int sender_pattern[4]   = '{0, 62, 0, 14};
	int receiver_pattern[4] = '{0, 0, 62, 14};

	dispenser_interlock_controller DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	dispenser_interlock_checker interlock_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.results_seen  (results_seen),
		.backlog       (backlog)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random; a zero percentage keeps it always ready.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Present one tick request and hold it until the block takes it.
	// Valid stays high on return so back-to-back requests need no extra assignment.
	task automatic send_tick(input logic [TankW-1:0] tank, input logic [CupW-1:0] cup,
			input logic rxv, input logic [CharW-1:0] rx);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, rx, cup, tank};
		s_axis_tuser  <= rxv;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// Drop valid and hold off until every tick result has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (results_seen < ticks_sent)
			@(posedge clk);
	endtask

	// Write the timeout register; call only with the block idle.
	task automatic write_timeout(input logic [TicksW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly pump commands, sometimes a zero byte or any byte at all.
	function automatic logic [CharW-1:0] pick_command();
		int c;
		c = $urandom_range(9);
		if (c <= 2)      return CMD_COKE;
		else if (c <= 5) return CMD_SPRITE;
		else if (c <= 7) return CMD_WATER;
		else if (c == 8) return CMD_NONE;
		return CharW'($urandom);
	endfunction

	// Random phase built from bursts: long quiet runs that let the timeout fire,
	// command sessions on clear sensors, single-fault injections and raw noise.
	task automatic run_phase(input int count, input int tmo);
		int               n;
		int               k;
		int               len;
		int               pick;
		int               f;
		logic [TankW-1:0] tank;
		logic [CupW-1:0]  cup;
		logic             rxv;
		logic [CharW-1:0] rx;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				// quiet run long enough to reach the timeout, except often short for timeouts above 40
				if (tmo <= 40 || $urandom_range(3) == 0)
					len = tmo + 2;
				else
					len = $urandom_range(30, 1);
			end else begin
				len = $urandom_range(10, 1);
			end
			for (k = 0; k < len && n < count; k++) begin
				tank = TANK_CLEAR;
				cup  = CUP_CLEAR;
				rxv  = 1'b0;
				rx   = CMD_NONE;
				if (pick < 12) begin
					// clear and silent: only the tick counter moves
				end else if (pick < 62) begin
					rxv = ($urandom_range(2) == 0);
					rx  = pick_command();
				end else if (pick < 82) begin
					f = $urandom_range(5);
					case (f)
						0:       tank[0] = 1'b0;
						1:       tank[1] = 1'b0;
						2:       tank[2] = 1'b1;
						3:       tank[3] = 1'b1;
						4:       cup[0]  = 1'b1;
						default: cup[1]  = 1'b1;
					endcase
					rxv = 1'($urandom_range(1));
					rx  = pick_command();
				end else begin
					tank = TankW'($urandom);
					cup  = CupW'($urandom);
					rxv  = 1'($urandom_range(1));
					rx   = CharW'($urandom);
				end
				send_tick(tank, cup, rxv, rx);
				n++;
			end
		end
	endtask

	initial begin
		int               p;
		int               tmo;
		int               total_fail;
		int               tmo_seen[PHASES];
		clk                = 1'b0;
		arst_n             = 1'b0;
		s_axis_tvalid      = 1'b0;
		s_axis_tdata       = '0;
		s_axis_tuser       = 1'b0;
		cfg_valid          = 1'b0;
		cfg_data           = '0;
		m_axis_tready      = 1'b0;
		ticks_sent         = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks at the reset timeout of 20, no idling.
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b0, CMD_NONE);  // nothing written yet
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, CMD_COKE);  // start coke
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, CMD_COKE);  // toggle it off
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, CMD_NONE);  // zero byte eaten, no effect
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, CMD_SPRITE); // start sprite
		send_tick(4'b0000, CUP_CLEAR, 1'b1, CMD_WATER);    // spill, byte left waiting
		send_tick(4'b0000, CUP_CLEAR, 1'b1, CMD_WATER);    // same fault, no rewrite
		send_tick(4'b0001, CUP_CLEAR, 1'b0, CMD_NONE);     // cup full
		send_tick(4'b0111, CUP_CLEAR, 1'b0, CMD_NONE);     // coke low
		send_tick(4'b1011, CUP_CLEAR, 1'b0, CMD_NONE);     // sprite low
		send_tick(TANK_CLEAR, 2'b01, 1'b0, CMD_NONE);      // water low
		send_tick(TANK_CLEAR, 2'b10, 1'b1, 8'hFF);         // cup missing
		send_tick(4'b1111, 2'b11, 1'b1, CMD_COKE);         // several faults, coke low wins
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, CMD_WATER); // select tick, byte not taken
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, CMD_WATER); // water toggles
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, CMD_ODD);   // other byte stops pumps
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, 8'hFF);     // top byte value
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b1, CMD_COKE);
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b0, CMD_NONE);
		send_tick(4'b1110, 2'b11, 1'b1, CMD_NONE);         // spill wins over everything
		send_tick(TANK_CLEAR, CUP_CLEAR, 1'b0, CMD_NONE);

		// Random phases; each boundary drains the block before the register changes.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0:       tmo = int'(TIMEOUT_RESET);
				1:       tmo = 1;
				2:       tmo = 255;
				3:       tmo = 0;
				4:       tmo = 5;
				6:       tmo = 2;
				7:       tmo = $urandom_range(40, 1);
				default: tmo = $urandom_range(255, 1);
			endcase
			tmo_seen[p] = tmo;
			drain_results();
			write_timeout(TicksW'(tmo));
			sender_idle_pct    = sender_pattern[p % 4];
			receiver_stall_pct = receiver_pattern[p % 4];
			run_phase(PHASE_TICKS, tmo);
		end

		drain_results();
		repeat (8) @(posedge clk);

		total_fail = fail_count + backlog;
		$display("Run covered %0d tick requests: directed fault and command cases, then %0d phases",
			ticks_sent, PHASES);
		$display("with timeouts %0d %0d %0d %0d %0d %0d %0d %0d under mixed stall patterns.",
			tmo_seen[0], tmo_seen[1], tmo_seen[2], tmo_seen[3],
			tmo_seen[4], tmo_seen[5], tmo_seen[6], tmo_seen[7]);
		if (total_fail == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
